[design/kwm_pkg.sv]
package kwm_pkg;

	localparam int MAX_WAYS = 16;
	localparam int WAY_W    = 4;
	localparam int VAL_W    = 32;
	localparam int NUM_W    = 5;
	// The minimum search works on groups of four heads: four groups of four.
	localparam int GRP      = 4;
	localparam int GRP_W    = 2;
	localparam int NGRP     = MAX_WAYS / GRP;

	typedef logic [WAY_W-1:0]        way_t;
	typedef logic signed [VAL_W-1:0] val_t;
	typedef logic [NUM_W-1:0]        num_t;

	typedef struct packed {
		way_t way;
		val_t value;
		logic stream_end;
		logic in_range;
	} item_t;

	typedef struct packed {
		logic             hit;
		logic [GRP_W-1:0] pos;
		val_t             value;
	} pick_t;

	function automatic num_t ways_used(num_t raw);
		num_t n;
		n = raw;
		if (raw < NUM_W'(2)) begin
			n = NUM_W'(2);
		end else if (raw > NUM_W'(MAX_WAYS)) begin
			n = NUM_W'(MAX_WAYS);
		end
		return n;
	endfunction

	// Smallest of up to four candidates; on equal values the lower position wins.
	// All pairwise compares are independent and run side by side.
	function automatic pick_t pick4(logic [GRP-1:0] cand, logic [GRP-1:0][VAL_W-1:0] vals);
		logic [GRP-1:0] win;
		logic           beats;
		pick_t          r;
		for (int j = 0; j < GRP; j++) begin
			win[j] = cand[j];
			for (int k = 0; k < GRP; k++) begin
				if (k != j) begin
					beats = !cand[k] || ($signed(vals[j]) < $signed(vals[k])) ||
						((vals[j] == vals[k]) && (j < k));
					win[j] = win[j] && beats;
				end
			end
		end
		r.hit   = |cand;
		r.pos   = '0;
		r.value = vals[0];
		for (int j = GRP - 1; j >= 0; j--) begin
			if (win[j]) begin
				r.pos   = GRP_W'(j);
				r.value = vals[j];
			end
		end
		return r;
	endfunction

endpackage

[design/kwm_if.sv]
interface kwm_in_if;
	logic                valid;
	logic                ready;
	kwm_pkg::way_t       way;
	kwm_pkg::val_t       value;
	logic                stream_end;

	modport source(output valid, output way, output value, output stream_end, input ready);
	modport sink(input valid, input way, input value, input stream_end, output ready);
endinterface

interface kwm_out_if;
	logic                valid;
	logic                ready;
	kwm_pkg::val_t       merged_value;
	kwm_pkg::way_t       source_way;
	logic                merge_done;

	modport source(output valid, output merged_value, output source_way, output merge_done,
		input ready);
	modport sink(input valid, input merged_value, input source_way, input merge_done,
		output ready);
endinterface

[design/kwm_front.sv]
module kwm_front (
	input  logic                  clk,
	input  logic                  arst_n,
	kwm_in_if.sink                in_ch,
	input  kwm_pkg::num_t         n,
	output kwm_pkg::item_t        item,
	output logic                  item_valid,
	input  logic                  item_pop
);

	kwm_pkg::item_t q_q [2];
	logic           rd_ptr_q;
	logic           wr_ptr_q;
	logic [1:0]     cnt_q;
	logic           push;
	kwm_pkg::item_t entry;

	assign in_ch.ready = (cnt_q != 2'd2);
	assign push        = in_ch.valid && in_ch.ready;
	assign item        = q_q[rd_ptr_q];
	assign item_valid  = (cnt_q != 2'd0);

	// Classify at the door: a way beyond the current count is marked out of range.
	always_comb begin
		entry.way        = in_ch.way;
		entry.value      = in_ch.value;
		entry.stream_end = in_ch.stream_end;
		entry.in_range   = (kwm_pkg::num_t'(in_ch.way) < n);
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wr_ptr_q] <= entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= 1'b0;
			wr_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (item_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			unique case ({push, item_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

[design/kwm_back.sv]
module kwm_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  kwm_pkg::num_t         n,
	input  kwm_pkg::item_t        item,
	input  logic                  item_valid,
	output logic                  item_pop,
	kwm_out_if.source             out_ch
);

	logic [kwm_pkg::MAX_WAYS-1:0] act_q;
	logic [kwm_pkg::MAX_WAYS-1:0] pres_q;
	kwm_pkg::val_t                head_q [kwm_pkg::MAX_WAYS];

	logic [kwm_pkg::MAX_WAYS-1:0] eff_act;
	logic [kwm_pkg::MAX_WAYS-1:0] eff_pres;
	logic [kwm_pkg::MAX_WAYS-1:0] act_d;
	logic [kwm_pkg::MAX_WAYS-1:0] pres_d;
	logic [kwm_pkg::MAX_WAYS-1:0] head_we;

	logic v_s1_q;
	logic v_s2_q;

	logic [kwm_pkg::NGRP-1:0]                   g_any;
	logic [kwm_pkg::NGRP-1:0]                   g_need;
	logic [kwm_pkg::NGRP-1:0]                   g_cand;
	logic [kwm_pkg::NGRP-1:0][kwm_pkg::VAL_W-1:0] g_val;
	kwm_pkg::way_t                              g_idx [kwm_pkg::NGRP];

	logic [kwm_pkg::NGRP-1:0]                   g_any_s2;
	logic [kwm_pkg::NGRP-1:0]                   g_need_s2;
	logic [kwm_pkg::NGRP-1:0]                   g_cand_s2;
	logic [kwm_pkg::NGRP-1:0][kwm_pkg::VAL_W-1:0] g_val_s2;
	kwm_pkg::way_t                              g_idx_s2 [kwm_pkg::NGRP];

	kwm_pkg::pick_t sel;
	kwm_pkg::way_t  best_way;
	logic           done_now;
	logic           emit_now;
	logic           res_now;
	logic           out_free;
	logic           s2_go;

	logic           out_v_q;
	kwm_pkg::val_t  out_val_q;
	kwm_pkg::way_t  out_way_q;
	logic           out_done_q;

	// Stage 1: reduce each group of four heads to its smallest candidate.
	always_comb begin
		logic [kwm_pkg::GRP-1:0]                     cand;
		logic [kwm_pkg::GRP-1:0][kwm_pkg::VAL_W-1:0] vals;
		kwm_pkg::pick_t                              gp;
		int                                          i;
		for (int g = 0; g < kwm_pkg::NGRP; g++) begin
			g_any[g]  = 1'b0;
			g_need[g] = 1'b0;
			for (int p = 0; p < kwm_pkg::GRP; p++) begin
				i = g * kwm_pkg::GRP + p;
				cand[p] = 1'b0;
				vals[p] = head_q[i];
				if ((kwm_pkg::num_t'(i) < n) && act_q[i]) begin
					g_any[g] = 1'b1;
					if (pres_q[i]) begin
						cand[p] = 1'b1;
					end else begin
						g_need[g] = 1'b1;
					end
				end
			end
			gp        = kwm_pkg::pick4(cand, vals);
			g_cand[g] = gp.hit;
			g_val[g]  = gp.value;
			g_idx[g]  = kwm_pkg::way_t'(g * kwm_pkg::GRP + int'(gp.pos));
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1_q) begin
			g_any_s2  <= g_any;
			g_need_s2 <= g_need;
			g_cand_s2 <= g_cand;
			g_val_s2  <= g_val;
			g_idx_s2  <= g_idx;
		end
	end

	// Stage 2: pick across groups and decide between done, emit or nothing.
	assign sel      = kwm_pkg::pick4(g_cand_s2, g_val_s2);
	assign best_way = g_idx_s2[sel.pos];
	assign done_now = !(|g_any_s2);
	assign emit_now = !done_now && !(|g_need_s2) && sel.hit;
	assign res_now  = done_now || emit_now;
	assign out_free = !out_v_q || out_ch.ready;
	assign s2_go    = v_s2_q && (!res_now || out_free);

	// A new transaction may enter in the same cycle the previous one retires;
	// it then sees the state as that retirement leaves it.
	assign item_pop = item_valid && !v_s1_q && (!v_s2_q || s2_go);

	always_comb begin
		logic hit;
		for (int i = 0; i < kwm_pkg::MAX_WAYS; i++) begin
			eff_act[i]  = (s2_go && done_now) ? 1'b1 : act_q[i];
			eff_pres[i] = pres_q[i];
			if (s2_go && done_now) begin
				eff_pres[i] = 1'b0;
			end else if (s2_go && emit_now && (best_way == kwm_pkg::way_t'(i))) begin
				eff_pres[i] = 1'b0;
			end
			hit = item_pop && item.in_range && (item.way == kwm_pkg::way_t'(i)) &&
				eff_act[i] && !eff_pres[i];
			act_d[i]   = (hit && item.stream_end) ? 1'b0 : eff_act[i];
			pres_d[i]  = (hit && !item.stream_end) ? 1'b1 : eff_pres[i];
			head_we[i] = hit && !item.stream_end;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < kwm_pkg::MAX_WAYS; i++) begin
			if (head_we[i]) begin
				head_q[i] <= item.value;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q   <= '1;
			pres_q  <= '0;
			v_s1_q  <= 1'b0;
			v_s2_q  <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			act_q  <= act_d;
			pres_q <= pres_d;
			v_s1_q <= item_pop;
			if (v_s1_q) begin
				v_s2_q <= 1'b1;
			end else if (s2_go) begin
				v_s2_q <= 1'b0;
			end
			if (s2_go && res_now) begin
				out_v_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s2_go && res_now) begin
			out_val_q  <= done_now ? '0 : sel.value;
			out_way_q  <= done_now ? '0 : best_way;
			out_done_q <= done_now;
		end
	end

	assign out_ch.valid        = out_v_q;
	assign out_ch.merged_value = out_val_q;
	assign out_ch.source_way   = out_way_q;
	assign out_ch.merge_done   = out_done_q;

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		!(v_s1_q && v_s2_q))
		else $error("two transactions in the search pipeline at once");

	a_pop_gap: assert property (@(posedge clk) disable iff (!arst_n)
		item_pop |=> !item_pop)
		else $error("transactions entered the back end on consecutive cycles");

	a_done_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(s2_go && done_now) |=> ($countones(act_q) >= kwm_pkg::MAX_WAYS - 1))
		else $error("ways still retired after a done result");

	a_way_in_count: assert property (@(posedge clk) disable iff (!arst_n)
		(s2_go && emit_now) |-> (kwm_pkg::num_t'(best_way) < n))
		else $error("emitted a head from a way beyond the count");

	a_emit_present: assert property (@(posedge clk) disable iff (!arst_n)
		(s2_go && emit_now) |-> pres_q[best_way])
		else $error("emitted a head that is not present");

endmodule

[design/k_way_merge_core.sv]
// Channel   Dir  Handshake           Payload
// in_ch     in   valid/ready         way, value, stream_end
// out_ch    out  valid/ready         merged_value, source_way, merge_done
// cfg       in   cfg_wr_en (no wait) cfg_wr_data = num_ways
//
// A transaction passes through the back end in three steps: apply to the head store,
// group search over four heads, then the cross-group pick that decides the result.
// The next transaction enters as the previous one retires, so the back end takes no
// new transaction before the last is through the two-stage minimum search loop.
// Reset clears the way marks, the queue and the output register at once; no sweep.
// A two-entry queue decouples input acceptance from the search; a held result in the
// output register stalls only the back end until out_ch takes it.
module k_way_merge_core (
	input  logic                  clk,
	input  logic                  arst_n,
	kwm_in_if.sink                in_ch,
	kwm_out_if.source             out_ch,
	input  logic                  cfg_wr_en,
	input  kwm_pkg::num_t         cfg_wr_data
);

	kwm_pkg::num_t  num_ways_q;
	kwm_pkg::num_t  n;
	kwm_pkg::item_t item;
	logic           item_valid;
	logic           item_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_ways_q <= kwm_pkg::num_t'(2);
		end else if (cfg_wr_en) begin
			num_ways_q <= cfg_wr_data;
		end
	end

	assign n = kwm_pkg::ways_used(num_ways_q);

	kwm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.n          (n),
		.item       (item),
		.item_valid (item_valid),
		.item_pop   (item_pop)
	);

	kwm_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.n          (n),
		.item       (item),
		.item_valid (item_valid),
		.item_pop   (item_pop),
		.out_ch     (out_ch)
	);

endmodule

[dv/k_way_merge_core_tb.sv]
`timescale 1ns / 1ps

module k_way_merge_core_tb;

	localparam int QUIET_LIMIT   = 2000;
	localparam int HOLD_CYCLES   = 200;
	localparam int SETTLE_CYCLES = 16;

	typedef struct packed {
		kwm_pkg::way_t way;
		kwm_pkg::val_t value;
		logic          stream_end;
	} way_item_t;

	typedef struct packed {
		kwm_pkg::val_t merged_value;
		kwm_pkg::way_t source_way;
		logic          merge_done;
	} merge_out_t;

	class merge_scoreboard;
		kwm_pkg::num_t ways_cfg;
		kwm_pkg::val_t heads[kwm_pkg::MAX_WAYS];
		bit            present[kwm_pkg::MAX_WAYS];
		bit            active[kwm_pkg::MAX_WAYS];
		merge_out_t    pending[$];
		int            items_seen;
		int            items_applied;
		int            results;
		int            dones;
		int            writes;
		int            errors;

		function new();
			ways_cfg = kwm_pkg::num_t'(2);
			clear_merge();
		endfunction

		function void clear_merge();
			for (int i = 0; i < kwm_pkg::MAX_WAYS; i++) begin
				heads[i]   = '0;
				present[i] = 1'b0;
				active[i]  = 1'b1;
			end
		endfunction

		function int unsigned ways_in_use();
			if (ways_cfg < 2) begin
				return 2;
			end
			if (ways_cfg > kwm_pkg::MAX_WAYS) begin
				return kwm_pkg::MAX_WAYS;
			end
			return ways_cfg;
		endfunction

		function void set_count(kwm_pkg::num_t v);
			ways_cfg = v;
			writes++;
		endfunction

		function bit awaiting(int unsigned w);
			return w < ways_in_use() && active[w] && !present[w];
		endfunction

		function int pending_count();
			return pending.size();
		endfunction

		// Applies one accepted transaction, then looks for the smallest head.
		// Ties keep the lowest way because only a strictly smaller head replaces it.
		function void note_item(way_item_t it);
			int unsigned n;
			int unsigned best;
			bit          any_active;
			bit          all_ready;
			bit          found;
			merge_out_t  r;
			n = ways_in_use();
			items_seen++;
			if (it.way < n && active[it.way] && !present[it.way]) begin
				items_applied++;
				if (it.stream_end) begin
					active[it.way] = 1'b0;
				end else begin
					heads[it.way]   = it.value;
					present[it.way] = 1'b1;
				end
			end
			any_active = 1'b0;
			all_ready  = 1'b1;
			found      = 1'b0;
			best       = 0;
			for (int i = 0; i < n; i++) begin
				if (active[i]) begin
					any_active = 1'b1;
					if (!present[i]) begin
						all_ready = 1'b0;
						break;
					end
					if (!found || heads[i] < heads[best]) begin
						best  = i;
						found = 1'b1;
					end
				end
			end
			if (!any_active) begin
				r.merged_value = '0;
				r.source_way   = '0;
				r.merge_done   = 1'b1;
				pending.push_back(r);
				clear_merge();
			end else if (all_ready && found) begin
				r.merged_value = heads[best];
				r.source_way   = kwm_pkg::way_t'(best);
				r.merge_done   = 1'b0;
				pending.push_back(r);
				present[best] = 1'b0;
			end
		endfunction

		task report(string msg);
			$display("MISMATCH at %0t: %s", $time, msg);
			errors++;
		endtask

		task check_output(merge_out_t got);
			merge_out_t want;
			if (pending.size() == 0) begin
				report($sformatf("unexpected result value=%0d way=%0d done=%0b",
					got.merged_value, got.source_way, got.merge_done));
				return;
			end
			want = pending.pop_front();
			results++;
			if (want.merge_done) begin
				dones++;
			end
			if (got.merged_value !== want.merged_value) begin
				report($sformatf("result %0d merged_value %0d, expected %0d",
					results, got.merged_value, want.merged_value));
			end
			if (got.source_way !== want.source_way) begin
				report($sformatf("result %0d source_way %0d, expected %0d",
					results, got.source_way, want.source_way));
			end
			if (got.merge_done !== want.merge_done) begin
				report($sformatf("result %0d merge_done %0b, expected %0b",
					results, got.merge_done, want.merge_done));
			end
		endtask
	endclass

	logic          clk;
	logic          arst_n;
	logic          cfg_wr_en;
	kwm_pkg::num_t cfg_wr_data;

	kwm_in_if  in_ch();
	kwm_out_if out_ch();

	k_way_merge_core u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.out_ch     (out_ch),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	merge_scoreboard sb;
	kwm_pkg::val_t   last_val[kwm_pkg::MAX_WAYS];
	bit              hold_output;
	bit              no_idle;
	int              quiet_cycles;
	merge_out_t      seen_out;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic way_item_t feed(int w, int v, bit e);
		way_item_t it;
		it.way        = kwm_pkg::way_t'(w);
		it.value      = v;
		it.stream_end = e;
		return it;
	endfunction

	// Mostly ascending values for a way that awaits one, with ties and wild values
	// mixed in; a few transactions go to random ways, which may ignore them.
	function automatic way_item_t pick_item(int end_pct);
		way_item_t   it;
		int unsigned open_ways[$];
		int unsigned r;
		for (int w = 0; w < kwm_pkg::MAX_WAYS; w++) begin
			if (sb.awaiting(w)) begin
				open_ways.push_back(w);
			end
		end
		it.way        = kwm_pkg::way_t'($urandom_range(0, kwm_pkg::MAX_WAYS - 1));
		it.value      = $urandom();
		it.stream_end = $urandom_range(0, 1);
		if (open_ways.size() == 0 || $urandom_range(0, 99) < 8) begin
			return it;
		end
		it.way        = kwm_pkg::way_t'(open_ways[$urandom_range(0, open_ways.size() - 1)]);
		it.stream_end = ($urandom_range(0, 99) < end_pct);
		r = $urandom_range(0, 99);
		if (it.stream_end) begin
			last_val[it.way] = $urandom();
		end else begin
			if (r < 10) begin
				it.value = $urandom();
			end else if (r < 25) begin
				it.value = int'($urandom_range(0, 6)) - 3;
			end else begin
				it.value = last_val[it.way] + kwm_pkg::val_t'($urandom_range(0, 999));
			end
			last_val[it.way] = it.value;
		end
		return it;
	endfunction

	task automatic send_item(input way_item_t it);
		in_ch.valid      <= 1'b1;
		in_ch.way        <= it.way;
		in_ch.value      <= it.value;
		in_ch.stream_end <= it.stream_end;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		sb.note_item(it);
	endtask

	task automatic sender_gap(input int pct);
		if (!no_idle && $urandom_range(0, 99) < pct) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
	endtask

	task automatic wait_results();
		@(posedge clk);
		while (sb.pending_count() != 0) @(posedge clk);
	endtask

	// Transactions that produce no result may still be inside the block when the
	// last result arrives, so let the pipeline settle before touching the register.
	task automatic write_count(input kwm_pkg::num_t v);
		in_ch.valid <= 1'b0;
		wait_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.set_count(v);
	endtask

	task automatic run_items(input int items, input int gap_pct, input int end_pct);
		int target;
		target = sb.items_applied + items;
		while (sb.items_applied < target) begin
			send_item(pick_item(end_pct));
			sender_gap(gap_pct);
		end
	endtask

	initial begin
		forever begin
			if (hold_output) begin
				out_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_output = 1'b0;
			end else if (!no_idle && $urandom_range(0, 99) < 15) begin
				out_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end else begin
				out_ch.ready <= 1'b1;
				repeat ($urandom_range(1, 30)) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				seen_out.merged_value = out_ch.merged_value;
				seen_out.source_way   = out_ch.source_way;
				seen_out.merge_done   = out_ch.merge_done;
				sb.check_output(seen_out);
			end
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Timeout: no transaction for %0d cycles, %0d results outstanding",
					quiet_cycles, sb.pending_count());
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	initial begin
		sb           = new();
		hold_output  = 1'b0;
		no_idle      = 1'b0;
		quiet_cycles = 0;
		for (int w = 0; w < kwm_pkg::MAX_WAYS; w++) begin
			last_val[w] = $urandom();
		end
		arst_n           <= 1'b0;
		in_ch.valid      <= 1'b0;
		in_ch.way        <= '0;
		in_ch.value      <= '0;
		in_ch.stream_end <= 1'b0;
		cfg_wr_en        <= 1'b0;
		cfg_wr_data      <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Two ways after reset: value extremes, equal heads, ignored transactions,
		// an empty stream and a merge completion after each group.
		send_item(feed(0, 32'h7fffffff, 1'b0));
		send_item(feed(1, 32'h80000000, 1'b0));
		send_item(feed(1, 32'h80000000, 1'b0));
		send_item(feed(1, -1, 1'b0));
		send_item(feed(1, 0, 1'b1));
		send_item(feed(0, 0, 1'b1));
		send_item(feed(0, 5, 1'b0));
		send_item(feed(1, 5, 1'b0));
		send_item(feed(0, 5, 1'b0));
		send_item(feed(0, 7, 1'b0));
		send_item(feed(15, 1, 1'b0));
		send_item(feed(0, 9, 1'b0));
		send_item(feed(1, 0, 1'b1));
		send_item(feed(1, 3, 1'b0));
		send_item(feed(0, 0, 1'b1));
		send_item(feed(0, 0, 1'b1));
		send_item(feed(1, 0, 1'b0));
		send_item(feed(1, 32'hffffffff, 1'b1));

		// Count changes land mid-merge; the rest of the state carries over.
		write_count(kwm_pkg::num_t'(16));
		run_items(45, 20, 15);
		write_count(kwm_pkg::num_t'(0));
		run_items(45, 20, 25);
		write_count(kwm_pkg::num_t'(31));
		hold_output = 1'b1;
		run_items(45, 0, 15);
		write_count(kwm_pkg::num_t'(5));
		run_items(45, 30, 20);
		write_count(kwm_pkg::num_t'(1));
		run_items(30, 10, 30);
		write_count(kwm_pkg::num_t'(9));
		run_items(25, 15, 20);
		in_ch.valid <= 1'b0;
		wait_results();
		run_items(25, 15, 20);
		write_count(kwm_pkg::num_t'(17));
		run_items(45, 15, 15);
		write_count(kwm_pkg::num_t'(3));
		run_items(45, 25, 25);
		write_count(kwm_pkg::num_t'(2));
		no_idle = 1'b1;
		run_items(50, 0, 20);

		in_ch.valid <= 1'b0;
		wait_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Sent %0d input transactions (%0d ignored by the block), checked %0d results",
			sb.items_seen, sb.items_seen - sb.items_applied, sb.results);
		$display("including %0d merge completions, over %0d way count settings.",
			sb.dones, sb.writes);
		if (sb.errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
